/* src/itda_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package itda_pkg;

   localparam int ValueWidth = 64;
   localparam int NarrowWidth = 32;
   localparam int NumDigits = 20;
   localparam int BcdWidth = 4 * NumDigits;
   localparam int BitCntWidth = $clog2(ValueWidth);
   localparam int DigitCntWidth = $clog2(NumDigits);

   localparam logic [6:0] CharZero = 7'd48;
   localparam logic [6:0] CharMinus = 7'd45;
   localparam logic [3:0] DigitMax = 4'd9;

   typedef struct packed {
      logic [ValueWidth-1:0] value;
      logic                  is_signed;
      logic                  is_wide;
   } req_type;

   typedef struct packed {
      logic [6:0] char_code;
      logic       last;
   } rsp_type;

   typedef enum logic [2:0] {
      StIdle,
      StConv,
      StSkip,
      StSign,
      StDigit
   } state_type;

endpackage

`default_nettype wire

/* src/integer_to_decimal_ascii.sv */
// operation: bit-serial double dabble over 32 (narrow) or 64 (wide) bits in StConv after the
// transfer in, then StSkip drops leading zero digits (up to 19) and leaves the scan; the sign, if
// any, is registered in StSign and the digits in StDigit, each held while the output stalls
// flow: one number at a time; a new number is taken only in StIdle, after the last character
// of the number before it has been registered
// reset: synchronous, clears the state machine and the output valid; no storage to clear
`timescale 1ns / 1ps
`default_nettype none

module integer_to_decimal_ascii
   import itda_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   state_type state_ff, state_in;

   logic [ValueWidth-1:0]    shift_ff, shift_in;
   logic [BcdWidth-1:0]      bcd_ff, bcd_in;
   logic [BitCntWidth-1:0]   bit_left_ff, bit_left_in;
   logic [DigitCntWidth-1:0] digit_left_ff, digit_left_in;
   logic                     neg_ff, neg_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_ff, rsp_in;

   logic                  req_xfer;
   logic                  load_ok;
   logic [ValueWidth-1:0] masked;
   logic [ValueWidth-1:0] magnitude;
   logic                  sign_bit;
   logic                  neg_now;
   logic [BcdWidth-1:0]   bcd_adj;
   logic [3:0]            top_digit;

   assign req_stall = (state_ff != StIdle);
   assign req_xfer = req_valid && !req_stall;
   assign load_ok = !rsp_valid_ff || !rsp_stall;
   assign top_digit = bcd_ff[BcdWidth-1 -: 4];

   always_comb begin
      masked = req_data.is_wide ? req_data.value
                                : {{(ValueWidth-NarrowWidth){1'b0}},
                                   req_data.value[NarrowWidth-1:0]};
      sign_bit = req_data.is_wide ? req_data.value[ValueWidth-1]
                                  : req_data.value[NarrowWidth-1];
      neg_now = req_data.is_signed && sign_bit;
      magnitude = masked;
      if (neg_now) begin
         magnitude = ~masked + {{(ValueWidth-1){1'b0}}, 1'b1};
         if (!req_data.is_wide) begin
            magnitude[ValueWidth-1:NarrowWidth] = '0;
         end
      end
   end

   // add 3 to every digit of 5 or more before the next shift
   always_comb begin
      for (int i = 0; i < NumDigits; i++) begin
         if (bcd_ff[4*i +: 4] >= 4'd5) begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4] + 4'd3;
         end else begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4];
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         StIdle: begin
            if (req_xfer) begin
               state_in = StConv;
            end
         end
         StConv: begin
            if (bit_left_ff == '0) begin
               state_in = StSkip;
            end
         end
         StSkip: begin
            if (top_digit != 4'd0 || digit_left_ff == '0) begin
               state_in = neg_ff ? StSign : StDigit;
            end
         end
         StSign: begin
            if (load_ok) begin
               state_in = StDigit;
            end
         end
         StDigit: begin
            if (load_ok && digit_left_ff == '0) begin
               state_in = StIdle;
            end
         end
         default: state_in = StIdle;
      endcase
   end

   always_comb begin
      shift_in = shift_ff;
      bcd_in = bcd_ff;
      bit_left_in = bit_left_ff;
      digit_left_in = digit_left_ff;
      neg_in = neg_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         StIdle: begin
            if (req_xfer) begin
               neg_in = neg_now;
               bcd_in = '0;
               // narrow operands sit at the top so the shift reads from one place
               if (req_data.is_wide) begin
                  shift_in = magnitude;
                  bit_left_in = BitCntWidth'(ValueWidth - 1);
               end else begin
                  shift_in = {magnitude[NarrowWidth-1:0], {(ValueWidth-NarrowWidth){1'b0}}};
                  bit_left_in = BitCntWidth'(NarrowWidth - 1);
               end
            end
         end
         StConv: begin
            bcd_in = {bcd_adj[BcdWidth-2:0], shift_ff[ValueWidth-1]};
            shift_in = {shift_ff[ValueWidth-2:0], 1'b0};
            bit_left_in = bit_left_ff - BitCntWidth'(1);
            digit_left_in = DigitCntWidth'(NumDigits - 1);
         end
         StSkip: begin
            if (top_digit == 4'd0 && digit_left_ff != '0) begin
               bcd_in = {bcd_ff[BcdWidth-5:0], 4'd0};
               digit_left_in = digit_left_ff - DigitCntWidth'(1);
            end
         end
         StSign: begin
            if (load_ok) begin
               rsp_in.char_code = CharMinus;
               rsp_in.last = 1'b0;
               rsp_valid_in = 1'b1;
            end
         end
         StDigit: begin
            if (load_ok) begin
               rsp_in.char_code = CharZero + {3'b000, top_digit};
               rsp_in.last = (digit_left_ff == '0);
               rsp_valid_in = 1'b1;
               bcd_in = {bcd_ff[BcdWidth-5:0], 4'd0};
               digit_left_in = digit_left_ff - DigitCntWidth'(1);
            end
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      bcd_ff <= bcd_in;
      bit_left_ff <= bit_left_in;
      digit_left_ff <= digit_left_in;
      neg_ff <= neg_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   a_accept_starts_conv: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff == StConv)
      else $error("accepted number did not start conversion");

   a_sign_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.char_code == CharMinus |-> !rsp_data.last)
      else $error("sign character marked last");

   a_char_is_digit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.char_code != CharMinus |->
      rsp_data.char_code >= CharZero && rsp_data.char_code <= CharZero + 7'd9)
      else $error("character is neither sign nor decimal digit");

   a_digit_is_bcd: assert property (@(posedge clock) disable iff (reset)
      state_ff == StDigit |-> top_digit <= DigitMax)
      else $error("converted digit out of decimal range");

endmodule

`default_nettype wire

/* tb/sv/tb_integer_to_decimal_ascii.sv */
`timescale 1ns / 1ps

module tb_integer_to_decimal_ascii;
   import itda_pkg::*;

   localparam int LongHold = 400;
   localparam int CycleLimit = 400000;
   localparam int RandomItems = 200;
   localparam int QuietItems = 30;
   localparam int SettleCycles = 120;

   typedef struct {
      logic [63:0] value;
      bit          is_signed;
      bit          is_wide;
      string       text;
   } directed_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   rsp_type char_expect_q[$];
   int      error_count = 0;
   int      cycle_count = 0;
   bit      send_gaps = 1'b1;
   bit      stall_gaps = 1'b1;
   bit      long_hold_pending = 1'b0;

   // empty text: characters come from the predictor
   directed_row_type directed_rows[] = '{
      '{64'h0000_0000_0000_0000, 1'b0, 1'b0, "0"},
      '{64'h0000_0000_0000_0000, 1'b1, 1'b1, "0"},
      '{64'h0000_0000_0000_0001, 1'b0, 1'b1, "1"},
      '{64'h0000_0000_0000_0009, 1'b1, 1'b0, "9"},
      '{64'h0000_0000_0000_000A, 1'b0, 1'b0, "10"},
      '{64'h0000_0000_FFFF_FFFF, 1'b0, 1'b0, "4294967295"},
      '{64'h0000_0000_FFFF_FFFF, 1'b1, 1'b0, "-1"},
      '{64'h0000_0000_8000_0000, 1'b1, 1'b0, "-2147483648"},
      '{64'h0000_0000_7FFF_FFFF, 1'b1, 1'b0, "2147483647"},
      '{64'h0000_0000_8000_0000, 1'b0, 1'b0, "2147483648"},
      '{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1, "18446744073709551615"},
      '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, "-1"},
      '{64'h8000_0000_0000_0000, 1'b1, 1'b1, "-9223372036854775808"},
      '{64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, "9223372036854775807"},
      '{64'h8000_0000_0000_0000, 1'b0, 1'b1, "9223372036854775808"},
      '{64'hFFFF_FFFF_0000_0000, 1'b0, 1'b0, "0"},
      '{64'hDEAD_BEEF_0000_0007, 1'b1, 1'b0, "7"},
      '{64'h1234_5678_8000_0000, 1'b1, 1'b0, "-2147483648"},
      '{64'hFFFF_FFFF_FFFF_FFF6, 1'b1, 1'b1, "-10"},
      '{64'h0000_0001_0000_0000, 1'b0, 1'b1, "4294967296"},
      '{64'h0000_0000_3B9A_CA00, 1'b0, 1'b0, ""},
      '{64'h0000_00E8_D4A5_0FFF, 1'b1, 1'b1, ""},
      '{64'hAB54_A98C_EB1F_0AD2, 1'b0, 1'b1, ""},
      '{64'h0DE0_B6B3_A763_FFFF, 1'b1, 1'b1, ""}
   };

   integer_to_decimal_ascii dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #2 clock = ~clock;

   function automatic void note_error(string msg);
      if (error_count < 10) $display("%s", msg);
      error_count++;
   endfunction

   // magnitude at the operand width, so the most negative value prints correctly
   function automatic void predict_text(req_type item);
      logic [63:0] mask;
      logic [63:0] magnitude;
      logic [3:0]  digit [NumDigits];
      int          count;
      bit          negative;
      rsp_type     ch;
      mask = item.is_wide ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h0000_0000_FFFF_FFFF;
      magnitude = item.value & mask;
      negative = item.is_signed && (item.is_wide ? magnitude[63] : magnitude[31]);
      if (negative) magnitude = (~magnitude + 64'd1) & mask;
      count = 0;
      do begin
         digit[count] = 4'(magnitude % 64'd10);
         magnitude = magnitude / 64'd10;
         count++;
      end while (magnitude != 64'd0);
      if (negative) begin
         ch.char_code = CharMinus;
         ch.last = 1'b0;
         char_expect_q.push_back(ch);
      end
      for (int k = count - 1; k >= 0; k--) begin
         ch.char_code = CharZero + 7'(digit[k]);
         ch.last = (k == 0);
         char_expect_q.push_back(ch);
      end
   endfunction

   function automatic void push_text(string text);
      rsp_type ch;
      for (int i = 0; i < text.len(); i++) begin
         ch.char_code = 7'(text[i]);
         ch.last = (i == text.len() - 1);
         char_expect_q.push_back(ch);
      end
   endfunction

   function automatic req_type random_item();
      req_type     item;
      logic [63:0] word;
      logic [63:0] power;
      word = {$urandom(), $urandom()};
      power = 64'd1;
      repeat ($urandom_range(0, 19)) power = power * 64'd10;
      case ($urandom_range(0, 5))
         0: item.value = word;
         1: item.value = word >> $urandom_range(1, 63);
         // around powers of ten, where the digit count changes
         2: item.value = power + 64'($urandom_range(0, 2)) - 64'd1;
         3: item.value = ~(power + 64'($urandom_range(0, 2)) - 64'd1) + 64'd1;
         4: begin
            case ($urandom_range(0, 3))
               0: item.value = {word[63:32], 32'h8000_0000};
               1: item.value = {word[63:32], 32'hFFFF_FFFF};
               2: item.value = 64'h8000_0000_0000_0000;
               default: item.value = {1'b0, word[62:0]} | 64'h7FFF_FFFF_FFFF_FFF0;
            endcase
         end
         default: item.value = {word[63:32], 32'($urandom_range(0, 99))};
      endcase
      item.is_signed = 1'($urandom_range(0, 1));
      item.is_wide = 1'($urandom_range(0, 1));
      return item;
   endfunction

   task automatic send_number(req_type item, string text);
      @(negedge clock);
      if (send_gaps && $urandom_range(0, 2) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_stall);
      if (text.len() == 0) predict_text(item);
      else push_text(text);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      wait (char_expect_q.size() == 0);
   endtask

   // receiver side: random stall bursts, or one long hold-off on request
   initial begin
      forever begin
         @(negedge clock);
         if (long_hold_pending) begin
            long_hold_pending = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LongHold) @(negedge clock);
            rsp_stall <= 1'b0;
         end else if (stall_gaps && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 5)) @(negedge clock);
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : check_chars
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (char_expect_q.size() == 0) begin
            note_error($sformatf("unexpected char 0x%02h last %0d",
                                 rsp_data.char_code, rsp_data.last));
         end else begin
            want = char_expect_q.pop_front();
            if (rsp_data.char_code !== want.char_code || rsp_data.last !== want.last)
               note_error($sformatf("char mismatch: expected 0x%02h last %0d, got 0x%02h last %0d",
                                    want.char_code, want.last,
                                    rsp_data.char_code, rsp_data.last));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      req_type item;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         item.value = directed_rows[i].value;
         item.is_signed = directed_rows[i].is_signed;
         item.is_wide = directed_rows[i].is_wide;
         send_number(item, directed_rows[i].text);
      end
      drain_results();

      for (int n = 0; n < RandomItems; n++) begin
         if (n == RandomItems / 4) drain_results();
         // back up the block behind a stalled output
         if (n == RandomItems / 2) begin
            long_hold_pending = 1'b1;
            send_gaps = 1'b0;
            repeat (8) send_number(random_item(), "");
            send_gaps = 1'b1;
         end
         send_number(random_item(), "");
      end

      send_gaps = 1'b0;
      stall_gaps = 1'b0;
      repeat (QuietItems) send_number(random_item(), "");

      drain_results();
      repeat (SettleCycles) @(posedge clock);
      if (error_count == 0 && char_expect_q.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

/* integer_to_decimal_ascii.f */
src/itda_pkg.sv
src/integer_to_decimal_ascii.sv
tb/sv/tb_integer_to_decimal_ascii.sv
